// File: hdl/cst_pkg.sv
package cst_pkg;

    // Scanner sizing
    localparam int KEYWORD_CHARS = 5;
    localparam int POSITION_BITS = 16;
    localparam int WORD_BITS     = KEYWORD_CHARS * 8;
    localparam int WCNT_BITS     = $clog2(KEYWORD_CHARS + 2);

    // Token queue sizing (entries of up to two tokens)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int KIND_BITS = 5;
    localparam int TOK_BITS  = 16;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PLUS   = 5'd0,
        KIND_MINUS  = 5'd1,
        KIND_MUL    = 5'd2,
        KIND_DIV    = 5'd3,
        KIND_NUM    = 5'd4,
        KIND_ERR    = 5'd5,
        KIND_RPAREN = 5'd6,
        KIND_LPAREN = 5'd7,
        KIND_END    = 5'd8,
        KIND_ID     = 5'd9,
        KIND_PRINT  = 5'd10,
        KIND_ASSIGN = 5'd11,
        KIND_SEMI   = 5'd12,
        KIND_IF     = 5'd13,
        KIND_ELSE   = 5'd14,
        KIND_ENDIF  = 5'd15,
        KIND_LT     = 5'd16,
        KIND_LEQ    = 5'd17,
        KIND_THEN   = 5'd18
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [TOK_BITS-1:0]  start;
        logic [TOK_BITS-1:0]  length;
    } t_token;

    // One queue entry: the tokens caused by one input word
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_entry;

endpackage

// File: hdl/cst_scan.sv
module cst_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [7:0]                   i_ch,
    input  logic                         i_end_of_text,
    output logic                         o_entry_valid,
    output cst_pkg::t_entry              o_entry
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_WORD = 2'd2,
        MODE_LT   = 2'd3
    } t_mode;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;

    localparam logic [cst_pkg::WORD_BITS-1:0] KW_PRINT =
        cst_pkg::WORD_BITS'(40'h7072696E74);
    localparam logic [cst_pkg::WORD_BITS-1:0] KW_IF    =
        cst_pkg::WORD_BITS'(40'h6966);
    localparam logic [cst_pkg::WORD_BITS-1:0] KW_ELSE  =
        cst_pkg::WORD_BITS'(40'h656C7365);
    localparam logic [cst_pkg::WORD_BITS-1:0] KW_ENDIF =
        cst_pkg::WORD_BITS'(40'h656E646966);
    localparam logic [cst_pkg::WORD_BITS-1:0] KW_THEN  =
        cst_pkg::WORD_BITS'(40'h7468656E);

    localparam logic [cst_pkg::POSITION_BITS-1:0] POS_MAX = '1;

    function automatic logic [cst_pkg::TOK_BITS-1:0] low16(
        input logic [cst_pkg::POSITION_BITS-1:0] p
    );
        logic [31:0] w;
        w = 32'(p);
        return w[cst_pkg::TOK_BITS-1:0];
    endfunction

    function automatic logic [cst_pkg::TOK_BITS-1:0] sat16(
        input logic [cst_pkg::POSITION_BITS-1:0] d
    );
        logic [31:0] w;
        w = 32'(d);
        return (w > 32'h0000FFFF) ? 16'hFFFF : w[cst_pkg::TOK_BITS-1:0];
    endfunction

    t_mode                              r_mode, n_mode;
    logic [cst_pkg::WORD_BITS-1:0]      r_word, n_word;
    logic [cst_pkg::WCNT_BITS-1:0]      r_wcnt, n_wcnt;
    logic [cst_pkg::POSITION_BITS-1:0]  r_begin, n_begin;
    logic [cst_pkg::POSITION_BITS-1:0]  r_pos, n_pos;

    logic            is_digit, is_letter;
    logic            do_close, do_start;
    logic            close_v, sec_v;
    cst_pkg::t_token close_tok, sec_tok;
    cst_pkg::t_kind  word_kind;

    assign is_digit  = (i_ch >= 8'h30) && (i_ch <= 8'h39);
    assign is_letter = ((i_ch >= 8'h61) && (i_ch <= 8'h7A)) ||
                       ((i_ch >= 8'h41) && (i_ch <= 8'h5A));

    // keyword match on the whole word: the char count and the chars must both agree
    always_comb begin
        word_kind = cst_pkg::KIND_ID;
        if (r_wcnt == cst_pkg::WCNT_BITS'(5) && r_word == KW_PRINT) begin
            word_kind = cst_pkg::KIND_PRINT;
        end else if (r_wcnt == cst_pkg::WCNT_BITS'(2) && r_word == KW_IF) begin
            word_kind = cst_pkg::KIND_IF;
        end else if (r_wcnt == cst_pkg::WCNT_BITS'(4) && r_word == KW_ELSE) begin
            word_kind = cst_pkg::KIND_ELSE;
        end else if (r_wcnt == cst_pkg::WCNT_BITS'(5) && r_word == KW_ENDIF) begin
            word_kind = cst_pkg::KIND_ENDIF;
        end else if (r_wcnt == cst_pkg::WCNT_BITS'(4) && r_word == KW_THEN) begin
            word_kind = cst_pkg::KIND_THEN;
        end
    end

    // token that is open, ending before the current position
    always_comb begin
        close_tok.start  = low16(r_begin);
        close_tok.length = sat16(r_pos - r_begin);
        unique case (r_mode)
            MODE_NUM:  close_tok.kind = cst_pkg::KIND_NUM;
            MODE_WORD: close_tok.kind = word_kind;
            MODE_LT: begin
                close_tok.kind   = cst_pkg::KIND_LT;
                close_tok.length = cst_pkg::TOK_BITS'(1);
            end
            default:   close_tok.kind = cst_pkg::KIND_ERR;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_word   = r_word;
        n_wcnt   = r_wcnt;
        n_begin  = r_begin;
        n_pos    = r_pos;
        do_close = 1'b0;
        do_start = 1'b0;
        close_v  = 1'b0;
        sec_v    = 1'b0;
        sec_tok.kind   = cst_pkg::KIND_ERR;
        sec_tok.start  = low16(r_pos);
        sec_tok.length = cst_pkg::TOK_BITS'(1);

        if (i_end_of_text) begin
            close_v        = (r_mode != MODE_IDLE);
            sec_v          = 1'b1;
            sec_tok.kind   = cst_pkg::KIND_END;
            sec_tok.length = '0;
            n_mode  = MODE_IDLE;
            n_word  = '0;
            n_wcnt  = '0;
            n_pos   = '0;
            n_begin = '0;
        end else begin
            unique case (r_mode)
                MODE_NUM: begin
                    if (!is_digit) begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_letter || is_digit) begin
                        n_word = {r_word[cst_pkg::WORD_BITS-9:0], i_ch};
                        if (r_wcnt <= cst_pkg::WCNT_BITS'(cst_pkg::KEYWORD_CHARS)) begin
                            n_wcnt = r_wcnt + 1'b1;
                        end
                    end else begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_LT: begin
                    if (i_ch == CH_EQ) begin
                        sec_v          = 1'b1;
                        sec_tok.kind   = cst_pkg::KIND_LEQ;
                        sec_tok.start  = low16(r_begin);
                        sec_tok.length = cst_pkg::TOK_BITS'(2);
                        n_mode         = MODE_IDLE;
                    end else begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase

            if (r_pos < POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end

            if (do_close) begin
                close_v = 1'b1;
                n_mode  = MODE_IDLE;
                n_word  = '0;
                n_wcnt  = '0;
            end

            if (do_start) begin
                if (i_ch == CH_SPACE || i_ch == CH_NL) begin
                    // skipped
                end else if (is_digit) begin
                    n_begin = r_pos;
                    n_mode  = MODE_NUM;
                end else if (is_letter) begin
                    n_begin = r_pos;
                    n_mode  = MODE_WORD;
                    n_word  = cst_pkg::WORD_BITS'(i_ch);
                    n_wcnt  = cst_pkg::WCNT_BITS'(1);
                end else if (i_ch == CH_LT) begin
                    n_begin = r_pos;
                    n_mode  = MODE_LT;
                end else begin
                    sec_v = 1'b1;
                    case (i_ch)
                        CH_PLUS:   sec_tok.kind = cst_pkg::KIND_PLUS;
                        CH_MINUS:  sec_tok.kind = cst_pkg::KIND_MINUS;
                        CH_MUL:    sec_tok.kind = cst_pkg::KIND_MUL;
                        CH_DIV:    sec_tok.kind = cst_pkg::KIND_DIV;
                        CH_LPAREN: sec_tok.kind = cst_pkg::KIND_LPAREN;
                        CH_RPAREN: sec_tok.kind = cst_pkg::KIND_RPAREN;
                        CH_EQ:     sec_tok.kind = cst_pkg::KIND_ASSIGN;
                        CH_SEMI:   sec_tok.kind = cst_pkg::KIND_SEMI;
                        default:   sec_tok.kind = cst_pkg::KIND_ERR;
                    endcase
                end
            end
        end
    end

    // pack: a lone token always sits in slot 0
    assign o_entry_valid = close_v || sec_v;
    assign o_entry.tok0  = close_v ? close_tok : sec_tok;
    assign o_entry.tok1  = sec_tok;
    assign o_entry.two   = close_v && sec_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_word  <= '0;
            r_wcnt  <= '0;
            r_begin <= '0;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_word  <= n_word;
            r_wcnt  <= n_wcnt;
            r_begin <= n_begin;
            r_pos   <= n_pos;
        end
    end

endmodule

// File: hdl/cst_tokq.sv
module cst_tokq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  cst_pkg::t_entry         i_entry,
    output logic                    o_full,
    input  logic                    i_pop,
    output logic                    o_empty,
    output cst_pkg::t_token         o_token,
    output logic                    o_last
);

    cst_pkg::t_entry                 r_mem [cst_pkg::QUEUE_DEPTH];
    logic [cst_pkg::QPTR_BITS-1:0]   r_wr, r_rd;
    logic [cst_pkg::QCNT_BITS-1:0]   r_cnt;
    logic                            r_sub;

    cst_pkg::t_entry head;
    logic            tok_pop, entry_pop;

    assign head      = r_mem[r_rd];
    assign o_empty   = (r_cnt == '0);
    assign o_full    = (r_cnt == cst_pkg::QCNT_BITS'(cst_pkg::QUEUE_DEPTH));
    assign o_token   = r_sub ? head.tok1 : head.tok0;
    assign o_last    = !head.two || r_sub;
    assign tok_pop   = i_pop && !o_empty;
    assign entry_pop = tok_pop && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_sub <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (entry_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (tok_pop) begin
                r_sub <= !o_last;
            end
            case ({i_push, entry_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/char_stream_tokenizer.sv
// Character tokenizer: one character (or end marker) per word in, tokens out.
// A token is written into the token queue with the word that closes it and is shown at the queue head.
// Throughput: one input word per cycle; a word may raise two tokens, popped one a cycle.
// Input stalls only when the four-entry token queue between scanner and output is full.
// Reset (i_rst_n low, synchronous): scanner idle, position zero, queue emptied.
module char_stream_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_text,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last
);

    logic            accept;
    logic            entry_valid;
    cst_pkg::t_entry entry;
    cst_pkg::t_token token;

    // A word is taken whenever the queue has room; words that make no token
    // (spaces, chars inside a number or word) only advance the scanner.
    assign accept = push && !full;

    // Front: scanner state, classification, keyword match
    cst_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_ch          (i_ch),
        .i_end_of_text (i_end_of_text),
        .o_entry_valid (entry_valid),
        .o_entry       (entry)
    );

    // Back: token queue, hands out one token per pop and marks the last one
    // of each input word.
    cst_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && entry_valid),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_token (token),
        .o_last  (o_last)
    );

    assign o_token_kind   = token.kind;
    assign o_token_start  = token.start;
    assign o_token_length = token.length;

endmodule
